// File: hdl/mtwg_pkg.sv
// ----------------------------------------------------------------------------
// mtwg_pkg
// Shared constants, types and the tempering function of the MT19937 word
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mtwg_pkg;

  localparam int MT_N = 624;
  localparam int MT_M = 397;
  localparam int IDX_W = $clog2(MT_N);

  localparam logic [31:0] MT_MATRIX       = 32'h9908_b0df;
  localparam logic [31:0] MT_UPPER        = 32'h8000_0000;
  localparam logic [31:0] MT_LOWER        = 32'h7fff_ffff;
  localparam logic [31:0] MT_MULT         = 32'd1812433253;
  localparam logic [31:0] MT_DEFAULT_SEED = 32'd5489;
  localparam logic [31:0] MT_TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] MT_TEMPER_C     = 32'hefc6_0000;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MT_N - 1);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_DRAW_RD,
    ST_DRAW_FAR,
    ST_DRAW_WR
  } ctrl_state_t;

  typedef struct packed {
    logic seed_load;
    logic seed_default;
    logic seed_mul;
    logic seed_write;
    logic draw_rd;
    logic draw_far;
    logic draw_wr;
    logic draw_commit;
  } dp_cmd_t;

  typedef struct packed {
    logic last_word;
    logic out_free;
  } dp_status_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & MT_TEMPER_B);
    y = y ^ ((y << 15) & MT_TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

// File: hdl/mtwg_ctrl.sv
// ----------------------------------------------------------------------------
// mtwg_ctrl
// Sequencer for reseed and draw transactions: walks the seeding recurrence
// and the read / twist / write steps of one draw.
// ----------------------------------------------------------------------------
`default_nettype none

module mtwg_ctrl (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cmd_valid,
  output logic                       cmd_stall,
  input  wire                        func,
  input  wire mtwg_pkg::dp_status_t  status,
  output mtwg_pkg::dp_cmd_t          cmd
);
  import mtwg_pkg::*;

  ctrl_state_t state, state_next;
  logic        seeded, seeded_next;
  logic        pending, pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      seeded  <= 1'b0;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      seeded  <= seeded_next;
      pending <= pending_next;
    end
  end

  always_comb begin
    state_next   = state;
    seeded_next  = seeded;
    pending_next = pending;
    cmd          = '0;
    cmd_stall    = 1'b1;
    case (state)
      ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          if (func) begin
            cmd.seed_load = 1'b1;
            pending_next  = 1'b0;
            state_next    = ST_SEED_MUL;
          end else if (!seeded) begin
            // draw before any seed: seed with the default first
            cmd.seed_load    = 1'b1;
            cmd.seed_default = 1'b1;
            pending_next     = 1'b1;
            state_next       = ST_SEED_MUL;
          end else begin
            state_next = ST_DRAW_RD;
          end
        end
      end
      ST_SEED_MUL: begin
        cmd.seed_mul = 1'b1;
        state_next   = ST_SEED_WR;
      end
      ST_SEED_WR: begin
        cmd.seed_write = 1'b1;
        if (status.last_word) begin
          seeded_next  = 1'b1;
          pending_next = 1'b0;
          state_next   = pending ? ST_DRAW_RD : ST_IDLE;
        end else begin
          state_next = ST_SEED_MUL;
        end
      end
      ST_DRAW_RD: begin
        cmd.draw_rd = 1'b1;
        state_next  = ST_DRAW_FAR;
      end
      ST_DRAW_FAR: begin
        cmd.draw_far = 1'b1;
        state_next   = ST_DRAW_WR;
      end
      ST_DRAW_WR: begin
        cmd.draw_wr = 1'b1;
        if (status.out_free) begin
          cmd.draw_commit = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/mtwg_datapath.sv
// ----------------------------------------------------------------------------
// mtwg_datapath
// 624-word state memory, seeding multiplier, twist and tempering logic and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtwg_datapath (
  input  wire                        clk,
  input  wire                        rst,
  input  wire mtwg_pkg::dp_cmd_t     cmd,
  output mtwg_pkg::dp_status_t       status,
  input  wire [31:0]                 seed_value,
  output logic                       word_valid,
  input  wire                        word_stall,
  output logic [31:0]                random_word
);
  import mtwg_pkg::*;

  logic [31:0] tbl_mem [MT_N];
  logic [31:0] rd_a, rd_b;
  idx_t        rd_addr_a, rd_addr_b;
  logic        we;
  idx_t        wr_addr;
  logic [31:0] wr_data;

  idx_t        pos;
  idx_t        j;
  logic [31:0] prev;
  logic [31:0] prod;
  logic [31:0] mix;
  logic        mix_lsb;

  idx_t          cur_i, nxt_i, far_i;
  logic [IDX_W:0] far_sum;
  logic [31:0]   seed_in;
  logic [31:0]   seed_word;
  logic [31:0]   twisted;

  // position arithmetic
  assign cur_i   = (32'(pos) >= 32'(MT_N)) ? '0 : pos;
  assign nxt_i   = (cur_i == LAST_IDX) ? '0 : cur_i + idx_t'(1);
  assign far_sum = {1'b0, cur_i} + (IDX_W+1)'(MT_M);
  assign far_i   = (32'(far_sum) >= 32'(MT_N)) ? IDX_W'(far_sum - (IDX_W+1)'(MT_N))
                                               : IDX_W'(far_sum);

  assign seed_in   = cmd.seed_default ? MT_DEFAULT_SEED : seed_value;
  assign seed_word = prod + {{(32-IDX_W){1'b0}}, j};
  assign twisted   = rd_a ^ (mix >> 1) ^ (mix_lsb ? MT_MATRIX : 32'h0);

  assign status.last_word = (j == LAST_IDX);
  assign status.out_free  = !word_valid || !word_stall;

  // memory ports
  assign rd_addr_a = cmd.draw_rd ? cur_i : far_i;
  assign rd_addr_b = nxt_i;

  always_comb begin
    we      = 1'b0;
    wr_addr = cur_i;
    wr_data = twisted;
    if (cmd.seed_load) begin
      we      = 1'b1;
      wr_addr = '0;
      wr_data = seed_in;
    end else if (cmd.seed_write) begin
      we      = 1'b1;
      wr_addr = j;
      wr_data = seed_word;
    end else if (cmd.draw_commit) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    rd_a <= tbl_mem[rd_addr_a];
    rd_b <= tbl_mem[rd_addr_b];
  end

  // seeding recurrence and twist operands
  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      prev <= seed_in;
      j    <= idx_t'(1);
    end else if (cmd.seed_write) begin
      prev <= seed_word;
      j    <= j + idx_t'(1);
    end
    if (cmd.seed_mul) begin
      prod <= MT_MULT * (prev ^ (prev >> 30));
    end
    if (cmd.draw_far) begin
      mix     <= (rd_a & MT_UPPER) | (rd_b & MT_LOWER);
      mix_lsb <= rd_b[0];
    end
  end

  // read position and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= LAST_IDX + idx_t'(1);
      word_valid <= 1'b0;
    end else begin
      if (cmd.seed_write && status.last_word) begin
        pos <= '0;
      end else if (cmd.draw_commit) begin
        pos <= nxt_i;
      end
      if (cmd.draw_commit) begin
        word_valid <= 1'b1;
      end else if (!word_stall) begin
        word_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_commit) begin
      random_word <= temper(twisted);
    end
  end

endmodule

`default_nettype wire

// File: hdl/mt19937_word_generator_unit.sv
// ----------------------------------------------------------------------------
// mt19937_word_generator_unit
// 32-bit MT19937 generator: reseeds its 624-word state or draws one tempered
// word per transaction, twisting the state one word per draw.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------
//  cmd     | cmd_valid/cmd_stall  | func, seed_value
//  word    | word_valid/word_stall| random_word
//
//  draw: per transaction, idle, two-port read of i and i+1, read of i+397,
//  then twist and write, in steps set by the read ports of the state memory
//  reseed: one 32x32 multiply and one write per state word after the first
//  first draw after reset reseeds with 5489 first
//  a finished word waits in the output register while word_stall is high;
//  the next draw holds at its write step until that register is free
// ----------------------------------------------------------------------------
`default_nettype none

module mt19937_word_generator_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         cmd_valid,
  output logic        cmd_stall,
  input  wire         func,
  input  wire  [31:0] seed_value,
  output logic        word_valid,
  input  wire         word_stall,
  output logic [31:0] random_word
);
  import mtwg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mtwg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .func      (func),
    .status    (status),
    .cmd       (cmd)
  );

  mtwg_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .seed_value  (seed_value),
    .word_valid  (word_valid),
    .word_stall  (word_stall),
    .random_word (random_word)
  );

  a_step_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.seed_mul, cmd.seed_write, cmd.draw_rd, cmd.draw_far, cmd.draw_wr}))
    else $error("more than one datapath step active");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.draw_commit |-> (!word_valid || !word_stall))
    else $error("draw committed over a pending word");

  a_word_from_draw: assert property (@(posedge clk) disable iff (rst)
    $rose(word_valid) |-> $past(cmd.draw_commit))
    else $error("word appeared without a draw");

  a_reseed_silent: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && func) |=> !$rose(word_valid))
    else $error("reseed produced a word");

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the MT19937 word generator against its own table-based predictor.
// Directed reseeds and draws come first, then random reseed-and-draw runs,
// with random gaps on the command side and random stalls on the word side.
// ----------------------------------------------------------------------------

module testbench;

  import mtwg_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 1500;
  localparam int TARGET_CMDS    = 1050;

  typedef struct {
    bit          func;
    logic [31:0] seed;
    bit          drain;
  } gen_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  logic        func = 1'b0;
  logic [31:0] seed_value = '0;
  logic        word_valid;
  logic        word_stall = 1'b0;
  logic [31:0] random_word;

  gen_cmd_t    cmd_pending[$];
  logic [31:0] words_due[$];
  int          cmds_total = 0;
  int          cmds_taken = 0;
  int          errors = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  int          calm_timer = 0;

  // predictor state
  logic [31:0] mt_state [MT_N];
  idx_t        mt_pos = idx_t'(MT_N);
  bit          mt_seeded = 1'b0;

  mt19937_word_generator_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .func        (func),
    .seed_value  (seed_value),
    .word_valid  (word_valid),
    .word_stall  (word_stall),
    .random_word (random_word)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void twister_seed(input logic [31:0] s);
    logic [31:0] prev;
    mt_state[0] = s;
    for (int j = 1; j < MT_N; j++) begin
      prev = mt_state[j-1];
      mt_state[j] = MT_MULT * (prev ^ (prev >> 30)) + 32'(j);
    end
    mt_pos = '0;
    mt_seeded = 1'b1;
  endfunction

  function automatic logic [31:0] twister_draw();
    int          i;
    int          nxt;
    int          far;
    logic [31:0] mix;
    logic [31:0] y;
    if (!mt_seeded) twister_seed(MT_DEFAULT_SEED);
    i = (mt_pos >= MT_N) ? 0 : int'(mt_pos);
    nxt = (i + 1) % MT_N;
    far = (i + MT_M) % MT_N;
    mix = (mt_state[i] & MT_UPPER) | (mt_state[nxt] & MT_LOWER);
    y = mt_state[far] ^ (mix >> 1) ^ (mt_state[nxt][0] ? MT_MATRIX : 32'h0);
    mt_state[i] = y;
    mt_pos = idx_t'(nxt);
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & MT_TEMPER_B);
    y = y ^ ((y << 15) & MT_TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic add_cmd(input bit f, input logic [31:0] s, input bit drain);
    gen_cmd_t c;
    c.func = f;
    c.seed = s;
    c.drain = drain;
    cmd_pending.push_back(c);
    cmds_total++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %08h want %08h", $time, what, got, want);
    errors++;
  endtask

  // quiet stretches with no idling on either side
  always @(posedge clk) begin
    calm_timer++;
    if (calm_timer % 400 == 0) calm <= ($urandom_range(0, 3) == 0);
  end

  // command driver
  always @(posedge clk) begin : cmd_driver
    static int gap_left = 0;
    static gen_cmd_t cur;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        if (cur.func) twister_seed(cur.seed);
        else words_due.push_back(twister_draw());
        cmds_taken++;
        gap_left = calm ? 0 : pick_gap();
      end
      if (!(cmd_valid && cmd_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (cmd_pending.size() > 0 &&
                     !(cmd_pending[0].drain && words_due.size() != 0)) begin
          cur = cmd_pending.pop_front();
          cmd_valid <= 1'b1;
          func <= cur.func;
          seed_value <= cur.seed;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // word monitor
  always @(posedge clk) begin : word_monitor
    static int stall_left = 0;
    logic [31:0] want;
    if (rst) begin
      word_stall <= 1'b0;
    end else begin
      if (word_valid && !word_stall) begin
        if (words_due.size() == 0) begin
          report_mismatch("word with nothing due", random_word, 32'h0);
        end else begin
          want = words_due.pop_front();
          if (random_word !== want) report_mismatch("random_word", random_word, want);
        end
      end
      if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        word_stall <= 1'b1;
      end else begin
        word_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && !cmd_stall) || (word_valid && !word_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout at %0t", $time);
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int run;
    // draws before any seed, then seed extremes and alternating bits
    add_cmd(1'b0, 32'h0, 1'b0);
    add_cmd(1'b0, 32'hffff_ffff, 1'b0);
    add_cmd(1'b0, 32'h0, 1'b0);
    add_cmd(1'b1, 32'h0, 1'b1);
    add_cmd(1'b0, 32'h0, 1'b0);
    add_cmd(1'b0, 32'h0, 1'b0);
    add_cmd(1'b1, 32'hffff_ffff, 1'b0);
    add_cmd(1'b0, 32'hffff_ffff, 1'b0);
    add_cmd(1'b0, 32'h0, 1'b0);
    add_cmd(1'b1, MT_DEFAULT_SEED, 1'b0);
    add_cmd(1'b0, 32'h1234_5678, 1'b0);
    add_cmd(1'b1, 32'h5555_5555, 1'b0);
    add_cmd(1'b0, 32'h0, 1'b0);
    add_cmd(1'b1, 32'haaaa_aaaa, 1'b0);
    add_cmd(1'b0, 32'h0, 1'b0);
    add_cmd(1'b1, 32'h0000_0001, 1'b0);
    add_cmd(1'b0, 32'h8000_0000, 1'b0);
    // back-to-back reseeds, only the last one counts
    add_cmd(1'b1, 32'hdead_beef, 1'b0);
    add_cmd(1'b1, 32'h8000_0000, 1'b0);
    add_cmd(1'b0, 32'h0, 1'b0);
    add_cmd(1'b0, 32'h7fff_ffff, 1'b0);
    // one long run that wraps the read position
    add_cmd(1'b1, $urandom, 1'b0);
    for (int k = 0; k < 700; k++) add_cmd(1'b0, $urandom, 1'b0);
    while (cmds_total < TARGET_CMDS) begin
      if ($urandom_range(0, 9) < 8) begin
        add_cmd(1'b1, $urandom, ($urandom_range(0, 19) == 0));
        run = $urandom_range(1, 40);
        for (int k = 0; k < run; k++) add_cmd(1'b0, $urandom, ($urandom_range(0, 99) == 0));
      end else if ($urandom_range(0, 1) == 0) begin
        add_cmd(1'b0, $urandom, 1'b0);
      end else begin
        add_cmd(1'b1, $urandom, 1'b0);
        add_cmd(1'b1, $urandom, 1'b0);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (cmds_taken < cmds_total || words_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
